[hdl/hrs_pkg.sv]
// Shared constants, types and a helper function of the HID report size scanner.
package hrs_pkg;

    localparam int SUM_WIDTH = 32;
    localparam int LEN_WIDTH = 30;
    localparam int VAL_WIDTH = 32;
    localparam int PROD_WIDTH = 2 * VAL_WIDTH;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int ID_WIDTH = 8;

    localparam logic [PROD_WIDTH-1:0] SUM_MAX = (SUM_WIDTH >= PROD_WIDTH) ? '1 :
        ((PROD_WIDTH'(1) << SUM_WIDTH) - PROD_WIDTH'(1));
    localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

    localparam logic REG_TARGET_ID = 1'b0;

    localparam logic [5:0] TAG_INPUT        = 6'h20;
    localparam logic [5:0] TAG_OUTPUT       = 6'h24;
    localparam logic [5:0] TAG_FEATURE      = 6'h2C;
    localparam logic [5:0] TAG_REPORT_SIZE  = 6'h1D;
    localparam logic [5:0] TAG_REPORT_ID    = 6'h21;
    localparam logic [5:0] TAG_REPORT_COUNT = 6'h25;

    typedef enum logic [1:0] {
        ST_FOUND         = 2'd0,
        ST_NOT_FOUND     = 2'd1,
        ST_TRUNCATED     = 2'd2,
        ST_UNEXPECTED_ID = 2'd3
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [SUM_WIDTH-1:0]   input_bits;
        logic [SUM_WIDTH-1:0]   output_bits;
        logic [SUM_WIDTH-1:0]   feature_bits;
        logic [ID_WIDTH-1:0]    target;
    } fin_t;

    function automatic logic [2:0] value_len(input logic [1:0] size_code);
        logic [2:0] len;
        case (size_code)
            2'd0:    len = 3'd0;
            2'd1:    len = 3'd1;
            2'd2:    len = 3'd2;
            default: len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

[hdl/hrs_in_if.sv]
// Descriptor byte channel interface.
interface hrs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[hdl/hrs_out_if.sv]
// Report length result channel interface.
interface hrs_out_if;
    import hrs_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [LEN_WIDTH-1:0] input_bytes;
    logic [LEN_WIDTH-1:0] output_bytes;
    logic [LEN_WIDTH-1:0] feature_bytes;

    modport source (output valid, output status, output input_bytes,
                    output output_bytes, output feature_bytes, input ready);
    modport sink (input valid, input status, input input_bytes,
                  input output_bytes, input feature_bytes, output ready);
endinterface

[hdl/hrs_apb_regs.sv]
// APB configuration register holding the target report ID.
module hrs_apb_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hrs_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [hrs_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [hrs_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output logic [hrs_pkg::ID_WIDTH-1:0]         target_id
);
    import hrs_pkg::*;

    logic [ID_WIDTH-1:0] target_reg;
    logic [ID_WIDTH-1:0] target_next;
    logic                sel_target;

    assign pready = 1'b1;
    assign sel_target = (paddr[APB_ADDR_WIDTH-1] == REG_TARGET_ID);

    always_comb
    begin
        target_next = target_reg;
        if (psel && penable && pwrite && pready && sel_target)
        begin
            target_next = pwdata[ID_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    assign prdata = sel_target ? APB_DATA_WIDTH'(target_reg) : '0;
    assign target_id = target_reg;

endmodule

[hdl/hrs_parser.sv]
// Input register, short item parser, report totals and final record register.
module hrs_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hrs_pkg::ID_WIDTH-1:0]  target_id,
    hrs_in_if.sink                        desc,
    output logic                          fin_valid,
    output hrs_pkg::fin_t                 fin,
    input  logic                          fin_ready
);
    import hrs_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;

    logic [2:0]            pending_reg, pending_next;
    logic [1:0]            shift_reg, shift_next;
    logic [5:0]            tag_reg, tag_next;
    logic [VAL_WIDTH-1:0]  accum_reg, accum_next;
    logic [VAL_WIDTH-1:0]  rid_reg, rid_next;
    logic [VAL_WIDTH-1:0]  size_reg, size_next;
    logic [VAL_WIDTH-1:0]  count_reg, count_next;
    logic [SUM_WIDTH-1:0]  prod_reg, prod_next;
    logic [SUM_WIDTH-1:0]  ibits_reg, ibits_next;
    logic [SUM_WIDTH-1:0]  obits_reg, obits_next;
    logic [SUM_WIDTH-1:0]  fbits_reg, fbits_next;
    logic                  found_reg, found_next;
    logic                  stopped_reg, stopped_next;
    logic                  fin_valid_reg, fin_valid_next;
    fin_t                  fin_reg, fin_next;

    logic                  fin_free;
    logic                  s1_move;
    logic                  done;
    logic                  match;
    logic [VAL_WIDTH-1:0]  mul_a, mul_b;
    logic [PROD_WIDTH-1:0] prod_full;
    logic [SUM_WIDTH-1:0]  prod_sat;
    logic [SUM_WIDTH-1:0]  add_base;
    logic [SUM_WIDTH:0]    add_sum;
    logic [SUM_WIDTH-1:0]  add_sat;
    status_t               status;

    assign fin_free = !fin_valid_reg || fin_ready;
    assign s1_move = in_valid_reg && (!in_last_reg || fin_free);
    assign desc.ready = !in_valid_reg || s1_move;
    assign match = (rid_reg == VAL_WIDTH'(target_id));

    always_comb
    begin
        pending_next = pending_reg;
        shift_next = shift_reg;
        tag_next = tag_reg;
        accum_next = accum_reg;
        done = 1'b0;
        if (s1_move && !stopped_reg)
        begin
            if (pending_reg == '0)
            begin
                tag_next = in_byte_reg[7:2];
                pending_next = value_len(in_byte_reg[1:0]);
                accum_next = '0;
                shift_next = '0;
                done = (pending_next == '0);
            end
            else
            begin
                accum_next = accum_reg | (VAL_WIDTH'(in_byte_reg) << {shift_reg, 3'b000});
                shift_next = shift_reg + 2'd1;
                pending_next = pending_reg - 3'd1;
                done = (pending_reg == 3'd1);
            end
        end
    end

    // The product of report size and count is kept ready for the next main item.
    always_comb
    begin
        mul_a = (tag_next == TAG_REPORT_SIZE) ? accum_next : size_reg;
        mul_b = (tag_next == TAG_REPORT_COUNT) ? accum_next : count_reg;
        prod_full = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
        prod_sat = (prod_full > SUM_MAX) ? SUM_MAX[SUM_WIDTH-1:0] : prod_full[SUM_WIDTH-1:0];
    end

    always_comb
    begin
        case (tag_next)
            TAG_INPUT:  add_base = ibits_reg;
            TAG_OUTPUT: add_base = obits_reg;
            default:    add_base = fbits_reg;
        endcase
        add_sum = {1'b0, add_base} + {1'b0, prod_reg};
        add_sat = add_sum[SUM_WIDTH] ? '1 : add_sum[SUM_WIDTH-1:0];
    end

    always_comb
    begin
        rid_next = rid_reg;
        size_next = size_reg;
        count_next = count_reg;
        prod_next = prod_reg;
        ibits_next = ibits_reg;
        obits_next = obits_reg;
        fbits_next = fbits_reg;
        found_next = found_reg;
        stopped_next = stopped_reg;
        status = ST_NOT_FOUND;
        fin_next = fin_reg;
        fin_valid_next = fin_valid_reg;

        if (done)
        begin
            case (tag_next)
                TAG_REPORT_ID:
                begin
                    if (target_id == '0)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        rid_next = accum_next;
                        if (accum_next == VAL_WIDTH'(target_id))
                        begin
                            found_next = 1'b1;
                        end
                    end
                end
                TAG_INPUT:
                begin
                    if (match)
                    begin
                        ibits_next = add_sat;
                    end
                end
                TAG_OUTPUT:
                begin
                    if (match)
                    begin
                        obits_next = add_sat;
                    end
                end
                TAG_FEATURE:
                begin
                    if (match)
                    begin
                        fbits_next = add_sat;
                    end
                end
                TAG_REPORT_SIZE:
                begin
                    size_next = accum_next;
                    prod_next = prod_sat;
                end
                TAG_REPORT_COUNT:
                begin
                    count_next = accum_next;
                    prod_next = prod_sat;
                end
                default:
                begin
                end
            endcase
        end

        if (stopped_next)
        begin
            status = ST_UNEXPECTED_ID;
        end
        else if (pending_next != '0)
        begin
            status = ST_TRUNCATED;
        end
        else if (found_next || (target_id == '0))
        begin
            status = ST_FOUND;
        end

        if (fin_ready)
        begin
            fin_valid_next = 1'b0;
        end

        if (s1_move && in_last_reg)
        begin
            fin_valid_next = 1'b1;
            fin_next.status = status;
            fin_next.input_bits = ibits_next;
            fin_next.output_bits = obits_next;
            fin_next.feature_bits = fbits_next;
            fin_next.target = target_id;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (desc.valid && desc.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
            pending_reg <= '0;
            shift_reg <= '0;
            tag_reg <= '0;
            accum_reg <= '0;
            rid_reg <= '0;
            size_reg <= '0;
            count_reg <= '0;
            prod_reg <= '0;
            ibits_reg <= '0;
            obits_reg <= '0;
            fbits_reg <= '0;
            found_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            fin_valid_reg <= fin_valid_next;
            if (s1_move && in_last_reg)
            begin
                pending_reg <= '0;
                shift_reg <= '0;
                tag_reg <= '0;
                accum_reg <= '0;
                rid_reg <= '0;
                size_reg <= '0;
                count_reg <= '0;
                prod_reg <= '0;
                ibits_reg <= '0;
                obits_reg <= '0;
                fbits_reg <= '0;
                found_reg <= 1'b0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                pending_reg <= pending_next;
                shift_reg <= shift_next;
                tag_reg <= tag_next;
                accum_reg <= accum_next;
                rid_reg <= rid_next;
                size_reg <= size_next;
                count_reg <= count_next;
                prod_reg <= prod_next;
                ibits_reg <= ibits_next;
                obits_reg <= obits_next;
                fbits_reg <= fbits_next;
                found_reg <= found_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc.valid && desc.ready)
        begin
            in_byte_reg <= desc.data_byte;
            in_last_reg <= desc.last_byte;
        end
        fin_reg <= fin_next;
    end

    assign fin_valid = fin_valid_reg;
    assign fin = fin_reg;

endmodule

[hdl/hrs_length.sv]
// Conversion of bit totals to byte lengths and the result output register.
module hrs_length (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fin_valid,
    input  hrs_pkg::fin_t  fin,
    output logic           fin_ready,
    hrs_out_if.source      result
);
    import hrs_pkg::*;

    localparam int NW = SUM_WIDTH - 2;
    localparam int EXT_W = (NW > LEN_WIDTH) ? NW : LEN_WIDTH;

    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg;
    logic [LEN_WIDTH-1:0] ilen_reg, olen_reg, flen_reg;
    logic                 id_byte;
    logic                 found;

    function automatic logic [LEN_WIDTH-1:0] to_len(input logic [SUM_WIDTH-1:0] bits,
                                                   input logic add_id);
        logic [NW-1:0]    n;
        logic [EXT_W-1:0] n_ext;
        n = NW'(bits[SUM_WIDTH-1:3]) + NW'(|bits[2:0]) + NW'((bits != '0) && add_id);
        n_ext = EXT_W'(n);
        return (n_ext > EXT_W'(LEN_MAX)) ? LEN_MAX : n_ext[LEN_WIDTH-1:0];
    endfunction

    assign fin_ready = !out_valid_reg || result.ready;
    assign id_byte = (fin.target != '0);
    assign found = (fin.status == ST_FOUND);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_valid && fin_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && fin_ready)
        begin
            status_reg <= fin.status;
            ilen_reg <= found ? to_len(fin.input_bits, id_byte) : '0;
            olen_reg <= found ? to_len(fin.output_bits, id_byte) : '0;
            flen_reg <= found ? to_len(fin.feature_bits, id_byte) : '0;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.status = status_reg;
    assign result.input_bytes = ilen_reg;
    assign result.output_bytes = olen_reg;
    assign result.feature_bytes = flen_reg;

endmodule

[hdl/hid_report_size_scanner_top.sv]
// Top level of the HID report size scanner.
//
// The desc channel takes one report descriptor byte per transaction, with
// last_byte marking the final byte of a descriptor. A descriptor streams in at
// one byte per clock while no last byte is held back by a full final record.
// After the transaction that carries the last byte, one transaction on the
// result channel gives the status and the input, output and feature report
// lengths in bytes. When the result channel is free, that byte passes through
// the input register, the final record register and the length conversion
// register on its way to the result.
// The user must write the target report ID over APB only while no descriptor
// is in flight; the block does not enforce this. It reads back at address 0.
// Reset clears the parser state, the totals and the target ID, and empties
// all pipeline registers. When the receiver stalls, the result is held and
// bytes other than a last byte keep being accepted; a second result can wait
// behind the held one, and a third last byte stalls the desc channel until
// the held result has moved on.
module hid_report_size_scanner_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hrs_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [hrs_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [hrs_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    hrs_in_if.sink                              desc,
    hrs_out_if.source                           result
);
    import hrs_pkg::*;

    logic [ID_WIDTH-1:0] target_id;
    logic                fin_valid;
    logic                fin_ready;
    fin_t                fin;

    hrs_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .target_id (target_id)
    );

    hrs_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .target_id (target_id),
        .desc      (desc),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_ready (fin_ready)
    );

    hrs_length u_length (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_ready (fin_ready),
        .result    (result)
    );

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !desc.ready |-> fin_valid)
        else $error("Descriptor channel stalled without a pending final record.");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && !fin_ready |=> fin_valid && $stable(fin))
        else $error("Final record changed while waiting for the output register.");

    a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && fin_ready |=> result.valid)
        else $error("Final record transfer did not produce a result transaction.");

endmodule

[sim/testbench.sv]
// Self-checking testbench of the HID report size scanner: descriptor streams against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrs_pkg::*;

    localparam int IDLE_PCT = 35;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 800;
    localparam int DESCRIPTORS_PER_PHASE = 7;
    localparam int TIMEOUT_NS = 200000;
    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_TARGET_ID =
        APB_ADDR_WIDTH'(4 * REG_TARGET_ID);
    localparam logic [7:0] LONG_ITEM_PREFIX = 8'hFE;
    localparam logic [LEN_WIDTH-1:0] SAT_LEN = 30'd536870913;
    localparam int VALUE_BYTES [4] = '{0, 1, 2, 4};

    typedef struct {
        status_t              status;
        logic [LEN_WIDTH-1:0] input_bytes;
        logic [LEN_WIDTH-1:0] output_bytes;
        logic [LEN_WIDTH-1:0] feature_bytes;
    } report_len_t;

    typedef struct {
        bit [7:0]    data;
        bit          last;
        bit          typed;
        report_len_t want;
    } desc_item_t;

    typedef struct packed {
        logic [7:0]           target;
        logic [7:0]           data;
        logic                 last;
        logic                 typed;
        status_t              status;
        logic [LEN_WIDTH-1:0] input_bytes;
        logic [LEN_WIDTH-1:0] output_bytes;
        logic [LEN_WIDTH-1:0] feature_bytes;
    } dir_row_t;

    localparam dir_row_t DIRECTED [27] = '{
        '{8'd0,   8'h00, 1'b1, 1'b1, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd0,   8'h85, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd0,   8'h01, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd0,   8'hFF, 1'b1, 1'b1, ST_UNEXPECTED_ID, 30'd0, 30'd0, 30'd0},
        '{8'd0,   8'h77, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd0,   8'hFF, 1'b1, 1'b1, ST_TRUNCATED,     30'd0, 30'd0, 30'd0},
        '{8'd255, 8'h77, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'h97, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'h85, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hFF, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'h80, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'h90, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd255, 8'hB0, 1'b1, 1'b1, ST_FOUND,         SAT_LEN, SAT_LEN, SAT_LEN},
        '{8'd1,   8'h85, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd1,   8'h02, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd1,   8'hFE, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd1,   8'h12, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd1,   8'h34, 1'b0, 1'b0, ST_FOUND,         30'd0, 30'd0, 30'd0},
        '{8'd1,   8'h90, 1'b1, 1'b1, ST_NOT_FOUND,     30'd0, 30'd0, 30'd0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    hrs_in_if  desc_ch ();
    hrs_out_if rep_ch ();

    hid_report_size_scanner_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .desc    (desc_ch),
        .result  (rep_ch)
    );

    always #2 clk = ~clk;

    // Parser state mirrored from the block.
    bit [7:0]  target_id;
    bit [2:0]  pend_bytes;
    bit [1:0]  byte_pos;
    bit [5:0]  cur_tag;
    bit [31:0] cur_value;
    bit [31:0] report_id;
    bit [31:0] report_size;
    bit [31:0] report_count;
    bit [63:0] in_total;
    bit [63:0] out_total;
    bit [63:0] feat_total;
    bit        id_seen;
    bit        halted;

    desc_item_t  desc_fifo[$];
    desc_item_t  on_wire;
    report_len_t pending_lengths[$];
    bit [7:0]    byte_buf[$];

    int desc_gap_pct = IDLE_PCT;
    int result_stall_pct = IDLE_PCT;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int random_bytes = 0;
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int reports_checked = 0;
    int target_writes = 0;
    int status_hits [4] = '{0, 0, 0, 0};

    task automatic log_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic bit [63:0] sat_add(input bit [63:0] total, input bit [63:0] amount);
        if (amount > SUM_MAX || total > SUM_MAX - amount)
        begin
            return SUM_MAX;
        end
        return total + amount;
    endfunction

    function automatic void close_item();
        bit [63:0] prod;
        bit        hit;
        prod = 64'(report_size) * 64'(report_count);
        hit = (report_id == 32'(target_id));
        case (cur_tag)
            TAG_REPORT_ID:
            begin
                if (target_id == 0)
                begin
                    halted = 1'b1;
                end
                else
                begin
                    report_id = cur_value;
                    if (cur_value == 32'(target_id))
                    begin
                        id_seen = 1'b1;
                    end
                end
            end
            TAG_INPUT:        if (hit) in_total = sat_add(in_total, prod);
            TAG_OUTPUT:       if (hit) out_total = sat_add(out_total, prod);
            TAG_FEATURE:      if (hit) feat_total = sat_add(feat_total, prod);
            TAG_REPORT_SIZE:  report_size = cur_value;
            TAG_REPORT_COUNT: report_count = cur_value;
            default:          ;
        endcase
    endfunction

    function automatic bit [LEN_WIDTH-1:0] bits_to_len(input bit [63:0] bits);
        bit [63:0] n;
        n = (bits >> 3) + 64'(bits[2:0] != 3'd0);
        if (n != 0 && target_id != 0)
        begin
            n = n + 1;
        end
        if (n > 64'(LEN_MAX))
        begin
            n = 64'(LEN_MAX);
        end
        return n[LEN_WIDTH-1:0];
    endfunction

    function automatic bit scan_byte(input bit [7:0] b, input bit last,
                                     output report_len_t res);
        if (!halted)
        begin
            if (pend_bytes == 0)
            begin
                cur_tag = b[7:2];
                pend_bytes = 3'(VALUE_BYTES[b[1:0]]);
                cur_value = '0;
                byte_pos = '0;
                if (pend_bytes == 0)
                begin
                    close_item();
                end
            end
            else
            begin
                cur_value |= 32'(b) << (8 * byte_pos);
                byte_pos = byte_pos + 2'd1;
                pend_bytes = pend_bytes - 3'd1;
                if (pend_bytes == 0)
                begin
                    close_item();
                end
            end
        end
        res.status = ST_FOUND;
        res.input_bytes = '0;
        res.output_bytes = '0;
        res.feature_bytes = '0;
        if (!last)
        begin
            return 1'b0;
        end
        if (halted)
        begin
            res.status = ST_UNEXPECTED_ID;
        end
        else if (pend_bytes != 0)
        begin
            res.status = ST_TRUNCATED;
        end
        else if (!(id_seen || target_id == 0))
        begin
            res.status = ST_NOT_FOUND;
        end
        if (res.status == ST_FOUND)
        begin
            res.input_bytes = bits_to_len(in_total);
            res.output_bytes = bits_to_len(out_total);
            res.feature_bytes = bits_to_len(feat_total);
        end
        pend_bytes = '0;
        byte_pos = '0;
        cur_tag = '0;
        cur_value = '0;
        report_id = '0;
        report_size = '0;
        report_count = '0;
        in_total = '0;
        out_total = '0;
        feat_total = '0;
        id_seen = 1'b0;
        halted = 1'b0;
        return 1'b1;
    endfunction

    // Byte sender; the predictor runs on every accepted transaction.
    always @(posedge clk)
    begin
        report_len_t predicted;
        bit          has_report;
        if (desc_ch.valid && desc_ch.ready)
        begin
            bytes_accepted++;
            has_report = scan_byte(on_wire.data, on_wire.last, predicted);
            if (has_report)
            begin
                pending_lengths.push_back(on_wire.typed ? on_wire.want : predicted);
            end
        end
        if (!desc_ch.valid || desc_ch.ready)
        begin
            if (desc_fifo.size() != 0 && $urandom_range(99) >= desc_gap_pct)
            begin
                on_wire = desc_fifo.pop_front();
                desc_ch.valid <= 1'b1;
                desc_ch.data_byte <= on_wire.data;
                desc_ch.last_byte <= on_wire.last;
            end
            else
            begin
                desc_ch.valid <= 1'b0;
            end
        end
    end

    task automatic check_len(input string name, input logic [LEN_WIDTH-1:0] got,
                             input logic [LEN_WIDTH-1:0] want);
        if (got !== want)
        begin
            log_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
        end
    endtask

    // Result receiver with random stalls and an occasional long hold-off.
    always @(posedge clk)
    begin
        report_len_t want;
        if (rep_ch.valid && rep_ch.ready)
        begin
            if (pending_lengths.size() == 0)
            begin
                log_mismatch("report length transaction with no descriptor pending");
            end
            else
            begin
                want = pending_lengths.pop_front();
                reports_checked++;
                status_hits[want.status]++;
                if (rep_ch.status !== want.status)
                begin
                    log_mismatch($sformatf("status is %0d, predicted %0d",
                                           rep_ch.status, want.status));
                end
                check_len("input_bytes", rep_ch.input_bytes, want.input_bytes);
                check_len("output_bytes", rep_ch.output_bytes, want.output_bytes);
                check_len("feature_bytes", rep_ch.feature_bytes, want.feature_bytes);
            end
        end
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rep_ch.ready <= 1'b0;
        end
        else
        begin
            rep_ch.ready <= ($urandom_range(99) >= result_stall_pct);
        end
    end

    task automatic apb_access(input bit write, input logic [APB_ADDR_WIDTH-1:0] addr,
                              input logic [APB_DATA_WIDTH-1:0] wdata,
                              output logic [APB_DATA_WIDTH-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_target(input bit [7:0] id);
        logic [APB_DATA_WIDTH-1:0] rd;
        apb_access(1'b1, ADDR_TARGET_ID, APB_DATA_WIDTH'(id), rd);
        target_id = id;
        target_writes++;
        apb_access(1'b0, ADDR_TARGET_ID, '0, rd);
        if (rd !== APB_DATA_WIDTH'(id))
        begin
            log_mismatch($sformatf("target ID reads back %0h, written %0h", rd, id));
        end
    endtask

    task automatic wait_drained();
        while (desc_fifo.size() != 0 || bytes_accepted != bytes_queued ||
               pending_lengths.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic ship_descriptor(input int cut);
        desc_item_t item;
        while (cut > 0 && byte_buf.size() > 1)
        begin
            void'(byte_buf.pop_back());
            cut--;
        end
        foreach (byte_buf[i])
        begin
            item.data = byte_buf[i];
            item.last = (i == byte_buf.size() - 1);
            item.typed = 1'b0;
            item.want = '{ST_FOUND, '0, '0, '0};
            desc_fifo.push_back(item);
            bytes_queued++;
        end
        random_bytes += byte_buf.size();
    endtask

    task automatic queue_random_descriptor();
        int        pick;
        bit [5:0]  tag;
        bit [1:0]  code;
        bit [31:0] value;
        byte_buf.delete();
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 12)) byte_buf.push_back(8'($urandom));
            ship_descriptor(0);
            return;
        end
        repeat ($urandom_range(1, 10))
        begin
            pick = $urandom_range(99);
            value = $urandom;
            if (pick < 15 && (target_id != 0 || $urandom_range(9) == 0))
            begin
                tag = TAG_REPORT_ID;
                if ($urandom_range(99) < 60)
                begin
                    value = 32'(target_id);
                end
                else if ($urandom_range(99) < 60)
                begin
                    value = $urandom_range(255);
                end
            end
            else if (pick < 35)
            begin
                tag = TAG_REPORT_SIZE;
                if ($urandom_range(9) != 0) value = $urandom_range(32);
            end
            else if (pick < 55)
            begin
                tag = TAG_REPORT_COUNT;
                if ($urandom_range(9) != 0) value = $urandom_range(64);
            end
            else if (pick < 85)
            begin
                case ($urandom_range(2))
                    0:       tag = TAG_INPUT;
                    1:       tag = TAG_OUTPUT;
                    default: tag = TAG_FEATURE;
                endcase
            end
            else if (pick < 93)
            begin
                tag = 6'($urandom_range(63));
            end
            else
            begin
                tag = LONG_ITEM_PREFIX[7:2];
            end
            if (pick >= 93)
            begin
                code = LONG_ITEM_PREFIX[1:0];
            end
            else if ($urandom_range(9) < 7)
            begin
                code = (value > 32'hFFFF) ? 2'd3 : (value > 32'hFF) ? 2'd2 :
                       (value != 0) ? 2'd1 : 2'd0;
            end
            else
            begin
                code = 2'($urandom_range(3));
            end
            byte_buf.push_back({tag, code});
            for (int i = 0; i < VALUE_BYTES[code]; i++)
            begin
                byte_buf.push_back(value[8*i +: 8]);
            end
        end
        ship_descriptor(($urandom_range(99) < 10) ? $urandom_range(1, 3) : 0);
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("hid_report_size_scanner_top: mismatch");
        $finish;
    end

    initial
    begin
        logic [APB_DATA_WIDTH-1:0] rd;
        desc_item_t                item;
        int                        phase;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        desc_ch.valid = 1'b0;
        desc_ch.data_byte = '0;
        desc_ch.last_byte = 1'b0;
        rep_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, ADDR_TARGET_ID, '0, rd);
        if (rd !== '0)
        begin
            log_mismatch($sformatf("target ID after reset reads %0h", rd));
        end

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].target != target_id)
            begin
                wait_drained();
                set_target(DIRECTED[i].target);
            end
            item.data = DIRECTED[i].data;
            item.last = DIRECTED[i].last;
            item.typed = DIRECTED[i].typed;
            item.want = '{DIRECTED[i].status, DIRECTED[i].input_bytes,
                          DIRECTED[i].output_bytes, DIRECTED[i].feature_bytes};
            desc_fifo.push_back(item);
            bytes_queued++;
        end

        phase = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            wait_drained();
            case (phase % 6)
                0:       set_target(8'd0);
                1:       set_target(8'd255);
                2:       set_target(8'd1);
                default: set_target(8'($urandom_range(255)));
            endcase
            desc_gap_pct = (phase == 2 || phase == 4) ? 0 : IDLE_PCT;
            result_stall_pct = (phase == 2) ? 0 : IDLE_PCT;
            if (phase == 4)
            begin
                hold_requests++;
            end
            repeat (DESCRIPTORS_PER_PHASE) queue_random_descriptor();
            phase++;
        end
        wait_drained();

        $display("Streamed %0d descriptor bytes into %0d reports over %0d target ID writes.",
                 bytes_accepted, reports_checked, target_writes);
        $display("Reports by status: found %0d, not found %0d, truncated %0d, bad ID %0d.",
                 status_hits[ST_FOUND], status_hits[ST_NOT_FOUND],
                 status_hits[ST_TRUNCATED], status_hits[ST_UNEXPECTED_ID]);
        if (mismatches == 0)
        begin
            $display("hid_report_size_scanner_top: match");
        end
        else
        begin
            $display("hid_report_size_scanner_top: mismatch");
        end
        $finish;
    end

endmodule
